FILE: rtl/ssbc_pkg.sv
// ----------------------------------------------------------------------------
// ssbc_pkg
// Shared types, codes and constants of the stationary sensor bias calibrator.
// ----------------------------------------------------------------------------
package ssbc_pkg;

    // Default parameter values.
    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths.
    localparam int OP_W         = 2;
    localparam int TEMP_W       = 16;
    localparam int PROG_W       = 7;
    localparam int MODE_W       = 2;
    localparam int TARGET_W     = 9;
    localparam int THRESH_W     = 23;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 23;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH  = 2;

    // Full scale of the progress figure.
    localparam int PERCENT      = 100;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CAL_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_TARGET = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_THRESH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY       = 2'd3;

    // Configuration reset values.
    localparam logic [MODE_W-1:0]   CAL_MODE_RESET = 2'd0;
    localparam logic [TARGET_W-1:0] TARGET_RESET   = 9'd200;
    localparam logic [THRESH_W-1:0] THRESH_RESET   = 23'd100;
    localparam logic [THRESH_W-1:0] GRAVITY_RESET  = 23'd9807;

    // Calibration modes.
    localparam logic [MODE_W-1:0] MODE_GYRO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BARO  = 2'd2;

    // Mean channels handled by the shared divider.
    localparam logic [1:0] CH_X = 2'd0;
    localparam logic [1:0] CH_Y = 2'd1;
    localparam logic [1:0] CH_Z = 2'd2;
    localparam logic [1:0] CH_T = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_ACK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SAMPLING = 2'd1,
        PH_COMPLETE = 2'd2,
        PH_FAILED   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CODE_OK     = 2'd0,
        CODE_BUSY   = 2'd1,
        CODE_MOTION = 2'd2
    } code_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_DECIDE,
        ST_CHECK,
        ST_MEANS,
        ST_STORE,
        ST_PROGRESS,
        ST_EMIT
    } bst_t;

    // Status of the queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        op_t  op;
    } fq_head_t;

endpackage

FILE: rtl/ssbc_if.sv
// ----------------------------------------------------------------------------
// ssbc_if
// Channel interfaces of the calibrator: input items, results, configuration.
// ----------------------------------------------------------------------------
interface ssbc_item_if
    import ssbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
();
    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               operation;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
    logic signed [TEMP_W-1:0]      temperature;

    modport source (
        output valid, operation, sample_x, sample_y, sample_z, temperature,
        input  ready
    );
    modport sink (
        input  valid, operation, sample_x, sample_y, sample_z, temperature,
        output ready
    );
endinterface

interface ssbc_result_if
    import ssbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    phase;
    logic [1:0]                    code;
    logic [PROG_W-1:0]             progress;
    logic signed [SAMPLE_BITS-1:0] cal_x;
    logic signed [SAMPLE_BITS-1:0] cal_y;
    logic signed [SAMPLE_BITS-1:0] cal_z;
    logic signed [TEMP_W-1:0]      cal_temp;

    modport source (
        output valid, phase, code, progress, cal_x, cal_y, cal_z, cal_temp,
        input  ready
    );
    modport sink (
        input  valid, phase, code, progress, cal_x, cal_y, cal_z, cal_temp,
        output ready
    );
endinterface

interface ssbc_cfg_if
    import ssbc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/ssbc_front.sv
// ----------------------------------------------------------------------------
// ssbc_front
// Accepts input transactions, decodes the operation and holds them in a short
// queue so that the back end can stall without blocking the input channel.
// ----------------------------------------------------------------------------
module ssbc_front
    import ssbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    ssbc_item_if.sink                     item,
    input  logic                          pop,
    output fq_head_t                      head,
    output logic signed [SAMPLE_BITS-1:0] head_x,
    output logic signed [SAMPLE_BITS-1:0] head_y,
    output logic signed [SAMPLE_BITS-1:0] head_z,
    output logic signed [TEMP_W-1:0]      head_temp
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push;
    logic              take;

    op_t                          op_q   [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] x_q   [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] y_q   [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] z_q   [QUEUE_DEPTH];
    logic signed [TEMP_W-1:0]      t_q   [QUEUE_DEPTH];

    // A transaction is taken whenever the queue has a free slot.
    assign item.ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;
    assign take       = pop && (fill_reg != '0);

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !take)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (take && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage; the operation is decoded on the way in.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg] <= op_t'(item.operation);
            x_q[wr_ptr_reg]  <= item.sample_x;
            y_q[wr_ptr_reg]  <= item.sample_y;
            z_q[wr_ptr_reg]  <= item.sample_z;
            t_q[wr_ptr_reg]  <= item.temperature;
        end
    end

    // Head of the queue.
    assign head.valid = (fill_reg != '0);
    assign head.op    = op_q[rd_ptr_reg];
    assign head_x     = x_q[rd_ptr_reg];
    assign head_y     = y_q[rd_ptr_reg];
    assign head_z     = z_q[rd_ptr_reg];
    assign head_temp  = t_q[rd_ptr_reg];

endmodule

FILE: rtl/ssbc_div.sv
// ----------------------------------------------------------------------------
// ssbc_div
// Unsigned restoring divider, one quotient bit per cycle, shared by the
// progress figure and the run means.
// ----------------------------------------------------------------------------
module ssbc_div
    import ssbc_pkg::*;
#(
    parameter int DIV_W = 32,
    parameter int DEN_W = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEP_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic [DIV_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    // One restoring step: bring down the next dividend bit and subtract.
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[DIV_W-2:0], fits};
            rem_next  = fits ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

FILE: rtl/ssbc_back.sv
// ----------------------------------------------------------------------------
// ssbc_back
// Executes queued operations: run control, accumulation, motion check, means
// through the shared divider, calibration store and the result register.
// ----------------------------------------------------------------------------
module ssbc_back
    import ssbc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    ssbc_cfg_if.sink                      cfg,
    input  fq_head_t                      head,
    input  logic signed [SAMPLE_BITS-1:0] head_x,
    input  logic signed [SAMPLE_BITS-1:0] head_y,
    input  logic signed [SAMPLE_BITS-1:0] head_z,
    input  logic signed [TEMP_W-1:0]      head_temp,
    output logic                          pop,
    ssbc_result_if.source                 result
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_N  = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SAMPLE_BITS + LOG_N;
    localparam int TSUM_W = TEMP_W + LOG_N;
    localparam int PNUM_W = CNT_W + PROG_W;
    localparam int DIV_A  = (SUM_W > TSUM_W) ? SUM_W : TSUM_W;
    localparam int DIV_W  = (DIV_A > PNUM_W) ? DIV_A : PNUM_W;
    localparam int MEAN_A = (SAMPLE_BITS > TEMP_W) ? SAMPLE_BITS : TEMP_W;
    localparam int MEAN_W = MEAN_A + 1;
    localparam int RNG_W  = (SAMPLE_BITS + 1 > THRESH_W + 1) ? SAMPLE_BITS + 1
                          : THRESH_W + 1;
    localparam int EXT_A  = (MEAN_W > THRESH_W + 1) ? MEAN_W : THRESH_W + 1;
    localparam int EXT_W  = EXT_A + 2;

    // Configuration registers.
    logic [MODE_W-1:0]   mode_cfg_reg;
    logic [TARGET_W-1:0] target_cfg_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic [THRESH_W-1:0] gravity_reg;

    // Run state.
    bst_t                          state_reg, state_next;
    logic [1:0]                    ch_reg, ch_next;
    phase_t                        phase_reg;
    code_t                         code_reg;
    logic                          busy_reg;
    logic                          finish_reg;
    logic [MODE_W-1:0]             run_mode_reg;
    logic [CNT_W-1:0]              run_target_reg;
    logic [CNT_W-1:0]              taken_reg;
    logic [CNT_W-1:0]              taken_inc;
    logic [CNT_W-1:0]              target_clamped;
    logic signed [SUM_W-1:0]       sum_reg  [3];
    logic signed [TSUM_W-1:0]      tsum_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg  [3];
    logic signed [SAMPLE_BITS-1:0] max_reg  [3];
    logic signed [MEAN_W-1:0]      mean_reg [4];
    logic signed [SAMPLE_BITS-1:0] cal_reg  [3];
    logic signed [TEMP_W-1:0]      cal_temp_reg;
    logic [PROG_W-1:0]             prog_reg;

    // Result register.
    logic                          res_valid_reg;
    logic [1:0]                    res_phase_reg;
    logic [1:0]                    res_code_reg;
    logic [PROG_W-1:0]             res_prog_reg;
    logic signed [SAMPLE_BITS-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic signed [TEMP_W-1:0]      res_temp_reg;

    // Sequencer strobes.
    logic div_start, sel_prog, mean_we, prog_we, do_fail, do_store, do_emit;

    // Datapath signals.
    logic signed [SAMPLE_BITS-1:0] samp [3];
    logic [2:0]                    moved;
    logic signed [RNG_W-1:0]       range_v [3];
    logic signed [RNG_W-1:0]       thr_ext;
    logic [SUM_W-1:0]              mag_axis [3];
    logic [TSUM_W-1:0]             mag_temp;
    logic [DIV_W-1:0]              half_n;
    logic [PNUM_W-1:0]             prog_num;
    logic [DIV_W-1:0]              div_num;
    logic                          div_done;
    logic [DIV_W-1:0]              div_quot;
    logic                          ch_neg;
    logic signed [MEAN_W-1:0]      q_mean;
    logic signed [EXT_W-1:0]       mean_ext [3];
    logic signed [EXT_W-1:0]       grav_ext;
    logic signed [SAMPLE_BITS-1:0] cal_new  [3];
    logic signed [TEMP_W-1:0]      cal_temp_new;
    logic [PROG_W-1:0]             prog_out;

    // Saturation to the sample range: keep the value if the upper bits are
    // all copies of the sign.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [EXT_W-1:0] v
    );
        logic [EXT_W-SAMPLE_BITS:0] top;
        top = v[EXT_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
        begin
            return v[SAMPLE_BITS-1:0];
        end
        else if (v[EXT_W-1])
        begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [TEMP_W-1:0] sat_temp(
        input logic signed [MEAN_W-1:0] v
    );
        logic [MEAN_W-TEMP_W:0] top;
        top = v[MEAN_W-1:TEMP_W-1];
        if ((&top) || !(|top))
        begin
            return v[TEMP_W-1:0];
        end
        else if (v[MEAN_W-1])
        begin
            return {1'b1, {(TEMP_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(TEMP_W-1){1'b1}}};
        end
    endfunction

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg   <= CAL_MODE_RESET;
            target_cfg_reg <= TARGET_RESET;
            thresh_reg     <= THRESH_RESET;
            gravity_reg    <= GRAVITY_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_CAL_MODE:      mode_cfg_reg   <= cfg.data[MODE_W-1:0];
                REG_SAMPLE_TARGET: target_cfg_reg <= cfg.data[TARGET_W-1:0];
                REG_MOTION_THRESH: thresh_reg     <= cfg.data[THRESH_W-1:0];
                REG_GRAVITY:       gravity_reg    <= cfg.data[THRESH_W-1:0];
            endcase
        end
    end

    // Sample count of a new run, held to one up to the maximum.
    always_comb
    begin
        if (target_cfg_reg == '0)
        begin
            target_clamped = CNT_W'(1);
        end
        else if (int'(target_cfg_reg) > MAX_SAMPLES)
        begin
            target_clamped = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            target_clamped = CNT_W'(target_cfg_reg);
        end
    end

    assign samp[0]   = head_x;
    assign samp[1]   = head_y;
    assign samp[2]   = head_z;
    assign taken_inc = taken_reg + CNT_W'(1);

    // Motion check: any axis whose spread exceeds the threshold.
    assign thr_ext = RNG_W'(thresh_reg);
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            range_v[a] = RNG_W'(max_reg[a]) - RNG_W'(min_reg[a]);
            moved[a]   = (range_v[a] > thr_ext);
        end
    end

    // Divider operands: magnitude of a sum plus half the count, or the
    // progress numerator.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag_axis[a] = sum_reg[a][SUM_W-1] ? SUM_W'(~sum_reg[a] + 1'b1)
                        : SUM_W'(sum_reg[a]);
        end
        mag_temp = tsum_reg[TSUM_W-1] ? TSUM_W'(~tsum_reg + 1'b1) : TSUM_W'(tsum_reg);
        half_n   = DIV_W'(run_target_reg >> 1);
        prog_num = PNUM_W'(taken_reg) * PNUM_W'(PERCENT);
        if (sel_prog)
        begin
            div_num = DIV_W'(prog_num);
        end
        else
        begin
            unique case (ch_next)
                CH_X: div_num = DIV_W'(mag_axis[0]) + half_n;
                CH_Y: div_num = DIV_W'(mag_axis[1]) + half_n;
                CH_Z: div_num = DIV_W'(mag_axis[2]) + half_n;
                CH_T: div_num = DIV_W'(mag_temp) + half_n;
            endcase
        end
    end

    ssbc_div #(
        .DIV_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (run_target_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Signed mean of the channel being divided.
    always_comb
    begin
        unique case (ch_reg)
            CH_X: ch_neg = sum_reg[0][SUM_W-1];
            CH_Y: ch_neg = sum_reg[1][SUM_W-1];
            CH_Z: ch_neg = sum_reg[2][SUM_W-1];
            CH_T: ch_neg = tsum_reg[TSUM_W-1];
        endcase
        q_mean = ch_neg ? -$signed(MEAN_W'(div_quot)) : $signed(MEAN_W'(div_quot));
    end

    // Calibration values from the means.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mean_ext[a] = EXT_W'(mean_reg[a]);
        end
        grav_ext     = EXT_W'(gravity_reg);
        cal_temp_new = sat_temp(mean_reg[3]);
        priority if (run_mode_reg == MODE_ACCEL)
        begin
            cal_new[0] = sat_sample(-mean_ext[0]);
            cal_new[1] = sat_sample(-mean_ext[1]);
            if (mean_reg[2] > 0)
            begin
                cal_new[2] = sat_sample(grav_ext - mean_ext[2]);
            end
            else
            begin
                cal_new[2] = sat_sample(-grav_ext - mean_ext[2]);
            end
        end
        else if (run_mode_reg == MODE_BARO)
        begin
            cal_new[0] = sat_sample(mean_ext[0]);
            cal_new[1] = '0;
            cal_new[2] = '0;
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                cal_new[a] = sat_sample(mean_ext[a]);
            end
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            ch_reg    <= CH_X;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // Sequencer next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        sel_prog   = 1'b0;
        mean_we    = 1'b0;
        prog_we    = 1'b0;
        do_fail    = 1'b0;
        do_store   = 1'b0;
        do_emit    = 1'b0;
        unique case (state_reg)
            ST_WAIT:
            begin
                if (head.valid && !res_valid_reg)
                begin
                    pop        = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (finish_reg)
                begin
                    state_next = ST_CHECK;
                end
                else if (phase_reg == PH_SAMPLING)
                begin
                    sel_prog   = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_PROGRESS;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_CHECK:
            begin
                if ((|moved) && (run_mode_reg != MODE_BARO))
                begin
                    do_fail    = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    ch_next    = CH_X;
                    div_start  = 1'b1;
                    state_next = ST_MEANS;
                end
            end
            ST_MEANS:
            begin
                if (div_done)
                begin
                    mean_we = 1'b1;
                    if (ch_reg == CH_T)
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        ch_next   = ch_reg + 2'd1;
                        div_start = 1'b1;
                    end
                end
            end
            ST_STORE:
            begin
                do_store   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_PROGRESS:
            begin
                sel_prog = 1'b1;
                if (div_done)
                begin
                    prog_we    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                do_emit    = 1'b1;
                state_next = ST_WAIT;
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // Run control and stored calibration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            code_reg       <= CODE_OK;
            busy_reg       <= 1'b0;
            finish_reg     <= 1'b0;
            run_mode_reg   <= MODE_GYRO;
            run_target_reg <= CNT_W'(1);
            taken_reg      <= '0;
            cal_reg[0]     <= '0;
            cal_reg[1]     <= '0;
            cal_reg[2]     <= '0;
            cal_temp_reg   <= '0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg   <= 1'b0;
                finish_reg <= 1'b0;
                unique case (head.op)
                    OP_SAMPLE:
                    begin
                        if (phase_reg == PH_SAMPLING)
                        begin
                            taken_reg  <= taken_inc;
                            finish_reg <= (taken_inc >= run_target_reg);
                        end
                    end
                    OP_START:
                    begin
                        if (phase_reg != PH_IDLE)
                        begin
                            busy_reg <= 1'b1;
                        end
                        else
                        begin
                            run_target_reg <= target_clamped;
                            run_mode_reg   <= (mode_cfg_reg == MODE_BARO) ? MODE_BARO
                                            : (mode_cfg_reg == MODE_ACCEL) ? MODE_ACCEL
                                            : MODE_GYRO;
                            taken_reg      <= '0;
                            phase_reg      <= PH_SAMPLING;
                            code_reg       <= CODE_OK;
                        end
                    end
                    OP_CANCEL:
                    begin
                        phase_reg <= PH_IDLE;
                        code_reg  <= CODE_OK;
                    end
                    OP_ACK:
                    begin
                        if (phase_reg == PH_COMPLETE || phase_reg == PH_FAILED)
                        begin
                            phase_reg <= PH_IDLE;
                        end
                    end
                endcase
            end
            if (do_fail)
            begin
                phase_reg <= PH_FAILED;
                code_reg  <= CODE_MOTION;
            end
            if (do_store)
            begin
                phase_reg    <= PH_COMPLETE;
                code_reg     <= CODE_OK;
                cal_reg[0]   <= cal_new[0];
                cal_reg[1]   <= cal_new[1];
                cal_reg[2]   <= cal_new[2];
                cal_temp_reg <= cal_temp_new;
            end
        end
    end

    // Accumulators, cleared by a start from idle.
    always_ff @(posedge clk)
    begin
        if (pop && head.op == OP_START && phase_reg == PH_IDLE)
        begin
            tsum_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
                min_reg[a] <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                max_reg[a] <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
        end
        else if (pop && head.op == OP_SAMPLE && phase_reg == PH_SAMPLING)
        begin
            tsum_reg <= tsum_reg + TSUM_W'(head_temp);
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= sum_reg[a] + SUM_W'(samp[a]);
                if (samp[a] < min_reg[a])
                begin
                    min_reg[a] <= samp[a];
                end
                if (samp[a] > max_reg[a])
                begin
                    max_reg[a] <= samp[a];
                end
            end
        end
    end

    // Means and progress from the divider.
    always_ff @(posedge clk)
    begin
        if (mean_we)
        begin
            mean_reg[ch_reg] <= q_mean;
        end
        if (prog_we)
        begin
            prog_reg <= PROG_W'(div_quot);
        end
    end

    // Progress figure shown with the result.
    always_comb
    begin
        unique case (phase_reg)
            PH_SAMPLING: prog_out = prog_reg;
            PH_COMPLETE: prog_out = PROG_W'(PERCENT);
            PH_IDLE:     prog_out = '0;
            PH_FAILED:   prog_out = '0;
        endcase
    end

    // Result register: holds one result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (do_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            res_phase_reg <= phase_reg;
            res_code_reg  <= busy_reg ? CODE_BUSY : code_reg;
            res_prog_reg  <= prog_out;
            res_x_reg     <= cal_reg[0];
            res_y_reg     <= cal_reg[1];
            res_z_reg     <= cal_reg[2];
            res_temp_reg  <= cal_temp_reg;
        end
    end

    assign result.valid    = res_valid_reg;
    assign result.phase    = res_phase_reg;
    assign result.code     = res_code_reg;
    assign result.progress = res_prog_reg;
    assign result.cal_x    = res_x_reg;
    assign result.cal_y    = res_y_reg;
    assign result.cal_z    = res_z_reg;
    assign result.cal_temp = res_temp_reg;

`ifndef ASSERT_OFF
    // A completed run always carries an ok code.
    a_complete_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COMPLETE) |-> (code_reg == CODE_OK))
        else $error("complete phase without ok code");

    // A failed run always carries the motion code.
    a_failed_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FAILED) |-> (code_reg == CODE_MOTION))
        else $error("failed phase without motion code");

    // Between items a sampling run has not yet reached its count.
    a_count_below: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SAMPLING && state_reg == ST_WAIT)
        |-> (taken_reg < run_target_reg))
        else $error("sampling run at or beyond its count");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_MEANS || state_reg == ST_PROGRESS))
        else $error("divider result with no consumer");
`endif

endmodule

FILE: rtl/stationary_sensor_bias_calibrator.sv
// ----------------------------------------------------------------------------
// stationary_sensor_bias_calibrator
// Averages a run of still three-axis samples with temperature into a gyro
// bias, an accel level offset or a baro ground pressure, with motion check.
//
//   Channel  Role    Payload
//   item     sink    operation, sample_x, sample_y, sample_z, temperature
//   result   source  phase, code, progress, cal_x, cal_y, cal_z, cal_temp
//   cfg      sink    index, data (cal_mode, sample_target, motion_threshold,
//                    gravity_value)
//
// During sampling the progress figure of an item is a division through the
// shared bit-serial divider, one bit per cycle.
// The sample that ends a run, unless motion fails it, takes four means, one
// after the other, through the same divider.
// Items outside sampling go from decode straight to the result register.
// A two-entry queue takes items while the back end works, if it has room; the
// result register holds one result and the back end waits while it is full.
// Reset is asynchronous and active low; there is no clearing pass.
// ----------------------------------------------------------------------------
module stationary_sensor_bias_calibrator
    import ssbc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    ssbc_item_if.sink     item,
    ssbc_result_if.source result,
    ssbc_cfg_if.sink      cfg
);

    fq_head_t                      head;
    logic                          pop;
    logic signed [SAMPLE_BITS-1:0] head_x;
    logic signed [SAMPLE_BITS-1:0] head_y;
    logic signed [SAMPLE_BITS-1:0] head_z;
    logic signed [TEMP_W-1:0]      head_temp;

    // Front: input queue and operation decode.
    ssbc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .pop       (pop),
        .head      (head),
        .head_x    (head_x),
        .head_y    (head_y),
        .head_z    (head_z),
        .head_temp (head_temp)
    );

    // Back: run control, accumulation, means and result register.
    ssbc_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .head_x    (head_x),
        .head_y    (head_y),
        .head_z    (head_z),
        .head_temp (head_temp),
        .pop       (pop),
        .result    (result)
    );

endmodule
